// ----- src/fcull_pkg.sv -----
package fcull_pkg;

	localparam int NUM_PLANES = 6;
	localparam int NEAR_IDX = 5;
	localparam int COEF_FRAC = 14;
	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int ROOT_W = 34;
	localparam int REM_W = 70;
	localparam int PADDR_W = 6;
	localparam int DATA_W = 64;

	localparam logic [2:0] FUNC_POINT = 3'd0;
	localparam logic [2:0] FUNC_SPHERE = 3'd1;
	localparam logic [2:0] FUNC_BOX = 3'd2;
	localparam logic [2:0] FUNC_SPHERE_DIST = 3'd3;
	localparam logic [2:0] FUNC_BOX_DIST = 3'd4;

	typedef struct packed {
		logic [2:0] func;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic [30:0] radius;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
	} req_t;

	typedef struct packed {
		logic inside_res;
		logic signed [31:0] near_dist;
	} rsp_t;

	// what rides along the square root stages
	typedef struct packed {
		logic [2:0] func;
		logic pt_in;
		logic sp_in;
		logic bx_in;
		logic signed [63:0] q;
		logic [31:0] sd;
	} sqp_t;

	function automatic logic signed [63:0] sx48(input logic signed [47:0] v);
		return {{16{v[47]}}, v};
	endfunction

	function automatic logic [31:0] sat_pos(input logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF) begin
			return 32'h7FFF_FFFF;
		end
		return v[31:0];
	endfunction

endpackage

// ----- src/frustum_cull_tests.sv -----
// six-plane frustum culling unit, Q16.16 coordinates
// planes are written over the apb port: six 64-bit registers at byte
// addresses 0x00..0x28 (right, left, bottom, top, far, near); each holds
// a, b, c as signed Q2.14 in bits 47:0 and d as a signed integer in 63:48.
// write planes only while no query is in flight.
// a query beat on req (func, box min / sphere center, radius, box max)
// yields exactly one beat on rsp (inside_res, near_dist).
// an accepted req beat passes three stages of products, plane sums and
// compares, 34 stages of a one-bit-per-stage square root for the box
// radius, and the output register before its rsp beat.
// throughput is one query per cycle while rsp is not stalled; every stage moves together.
// when the receiver stalls a valid rsp beat, the whole pipeline holds and
// req_stall rises in the same cycle; nothing is dropped or repeated.
// arst_n clears all valid bits and the plane registers (all-zero planes
// reject points and FUNC_BOX boxes; spheres and distance boxes pass unless zero-sized).
module frustum_cull_tests #(
	parameter int COORD_FRAC_BITS = fcull_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  fcull_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output fcull_pkg::rsp_t rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [fcull_pkg::PADDR_W-1:0] paddr,
	input  logic [fcull_pkg::DATA_W-1:0] pwdata,
	output logic [fcull_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	localparam int DSHIFT = COORD_FRAC_BITS + fcull_pkg::COEF_FRAC;
	localparam int NP = fcull_pkg::NUM_PLANES;
	localparam int NR = fcull_pkg::NEAR_IDX;
	localparam int RW = fcull_pkg::ROOT_W;
	localparam int MW = fcull_pkg::REM_W;

	logic [63:0] plane_q [NP];
	logic [2:0] widx;
	logic en;

	assign pready = 1'b1;
	assign widx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NP; p++) plane_q[p] <= '0;
		end else if (psel && penable && pwrite && pready && widx < 3'(NP)) begin
			plane_q[widx] <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (widx < 3'(NP)) prdata = plane_q[widx];
	end

	assign en = !rsp_valid || !rsp_stall;
	assign req_stall = !en;

	// stage 1: coefficient products for both box corners, extents
	logic v_s1;
	logic [2:0] func_s1;
	logic signed [47:0] p0_s1 [NP][3];
	logic signed [47:0] p1_s1 [NP][3];
	logic [32:0] ext_s1 [3];
	logic [44:0] r14_s1;
	logic signed [31:0] c0 [3];
	logic signed [31:0] c1 [3];

	assign c0[0] = req.ax;
	assign c0[1] = req.ay;
	assign c0[2] = req.az;
	assign c1[0] = req.bx;
	assign c1[1] = req.by;
	assign c1[2] = req.bz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= req.func;
			r14_s1 <= {req.radius, 14'd0};
			for (int k = 0; k < 3; k++) begin
				if (c1[k] >= c0[k]) begin
					ext_s1[k] <= 33'({c1[k][31], c1[k]} - {c0[k][31], c0[k]});
				end else begin
					ext_s1[k] <= 33'({c0[k][31], c0[k]} - {c1[k][31], c1[k]});
				end
				for (int p = 0; p < NP; p++) begin
					p0_s1[p][k] <= $signed(plane_q[p][16*k +: 16]) * c0[k];
					p1_s1[p][k] <= $signed(plane_q[p][16*k +: 16]) * c1[k];
				end
			end
		end
	end

	// stage 2: plane sums, box corner maxima, extent squares
	logic v_s2;
	logic [2:0] func_s2;
	logic signed [63:0] val_s2 [NP];
	logic signed [63:0] bmax_s2 [NP];
	logic signed [63:0] q_s2;
	logic [65:0] sq_s2 [3];
	logic [44:0] r14_s2;
	logic signed [63:0] dsc [NP];

	always_comb begin
		for (int p = 0; p < NP; p++) begin
			dsc[p] = $signed({{48{plane_q[p][63]}}, plane_q[p][63:48]}) <<< DSHIFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			r14_s2 <= r14_s1;
			for (int k = 0; k < 3; k++) sq_s2[k] <= 66'(ext_s1[k]) * 66'(ext_s1[k]);
			for (int p = 0; p < NP; p++) begin
				val_s2[p] <= fcull_pkg::sx48(p0_s1[p][0]) + fcull_pkg::sx48(p0_s1[p][1])
					+ fcull_pkg::sx48(p0_s1[p][2]) + dsc[p];
				bmax_s2[p] <= fcull_pkg::sx48(p1_s1[p][0] > p0_s1[p][0] ? p1_s1[p][0] : p0_s1[p][0])
					+ fcull_pkg::sx48(p1_s1[p][1] > p0_s1[p][1] ? p1_s1[p][1] : p0_s1[p][1])
					+ fcull_pkg::sx48(p1_s1[p][2] > p0_s1[p][2] ? p1_s1[p][2] : p0_s1[p][2])
					+ dsc[p];
			end
			// twice the center distance: a*(min+max) summed, d doubled
			q_s2 <= fcull_pkg::sx48(p0_s1[NR][0]) + fcull_pkg::sx48(p1_s1[NR][0])
				+ fcull_pkg::sx48(p0_s1[NR][1]) + fcull_pkg::sx48(p1_s1[NR][1])
				+ fcull_pkg::sx48(p0_s1[NR][2]) + fcull_pkg::sx48(p1_s1[NR][2])
				+ (dsc[NR] <<< 1);
		end
	end

	// stage 3 feeds entry 0 of the root pipeline
	logic v_sq [RW+1];
	logic [MW-1:0] rem_sq [RW+1];
	logic [RW-1:0] root_sq [RW+1];
	fcull_pkg::sqp_t pay_sq [RW+1];
	logic signed [63:0] r14w;
	logic signed [63:0] sdv;
	logic pt_all, sp_all, bx_all;

	always_comb begin
		r14w = $signed({19'd0, r14_s2});
		pt_all = 1'b1;
		sp_all = 1'b1;
		bx_all = 1'b1;
		for (int p = 0; p < NP; p++) begin
			if (val_s2[p] <= 0) pt_all = 1'b0;
			if (val_s2[p] + r14w <= 0) sp_all = 1'b0;
			if (bmax_s2[p] <= 0) bx_all = 1'b0;
		end
		sdv = (val_s2[NR] + r14w) >>> fcull_pkg::COEF_FRAC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq[0] <= 1'b0;
		end else if (en) begin
			v_sq[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sq[0] <= MW'(sq_s2[0]) + MW'(sq_s2[1]) + MW'(sq_s2[2]);
			root_sq[0] <= '0;
			pay_sq[0].func <= func_s2;
			pay_sq[0].pt_in <= pt_all;
			pay_sq[0].sp_in <= sp_all;
			pay_sq[0].bx_in <= bx_all;
			pay_sq[0].q <= q_s2;
			pay_sq[0].sd <= fcull_pkg::sat_pos(sdv);
		end
	end

	// one root bit per stage, remainder form: rem = S - root^2
	for (genvar k = 0; k < RW; k++) begin : g_root
		localparam int B = RW - 1 - k;
		logic [MW-1:0] trial;

		assign trial = (MW'(root_sq[k]) << (B + 1)) + (MW'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sq[k+1] <= 1'b0;
			end else if (en) begin
				v_sq[k+1] <= v_sq[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pay_sq[k+1] <= pay_sq[k];
				if (rem_sq[k] >= trial) begin
					rem_sq[k+1] <= rem_sq[k] - trial;
					root_sq[k+1] <= root_sq[k] | (RW'(1) << B);
				end else begin
					rem_sq[k+1] <= rem_sq[k];
					root_sq[k+1] <= root_sq[k];
				end
			end
		end
	end

	// output stage
	fcull_pkg::sqp_t pf;
	logic signed [63:0] qt;
	logic bd_in;
	fcull_pkg::rsp_t rsp_d;

	always_comb begin
		pf = pay_sq[RW];
		qt = pf.q + $signed({16'd0, root_sq[RW], 14'd0});
		bd_in = qt > 0;
		rsp_d = '0;
		case (pf.func)
			fcull_pkg::FUNC_POINT: begin
				rsp_d.inside_res = pf.pt_in;
			end
			fcull_pkg::FUNC_SPHERE: begin
				rsp_d.inside_res = pf.sp_in;
			end
			fcull_pkg::FUNC_BOX: begin
				rsp_d.inside_res = pf.bx_in;
			end
			fcull_pkg::FUNC_SPHERE_DIST: begin
				rsp_d.inside_res = pf.sp_in;
				if (pf.sp_in) rsp_d.near_dist = pf.sd;
			end
			fcull_pkg::FUNC_BOX_DIST: begin
				rsp_d.inside_res = bd_in;
				if (bd_in) rsp_d.near_dist = fcull_pkg::sat_pos(qt >>> (fcull_pkg::COEF_FRAC + 1));
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (en) begin
			rsp_valid <= v_sq[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) rsp <= rsp_d;
	end

endmodule

// ----- tb/tb_frustum_cull_tests.sv -----
`timescale 1ns / 1ps

module tb_frustum_cull_tests;

	localparam int REG_RIGHT = 0;
	localparam int REG_LEFT = 1;
	localparam int REG_BOTTOM = 2;
	localparam int REG_TOP = 3;
	localparam int REG_FAR = 4;
	localparam int REG_NEAR = 5;
	localparam int PIPE_DEPTH = 38;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 280;
	localparam int PADDR_W = fcull_pkg::PADDR_W;
	localparam int DATA_W = fcull_pkg::DATA_W;
	localparam int NUM_PLANES = fcull_pkg::NUM_PLANES;

	// func codes with no operation behind them
	localparam logic [2:0] FUNC_UNUSED5 = 3'd5;
	localparam logic [2:0] FUNC_UNUSED6 = 3'd6;
	localparam logic [2:0] FUNC_UNUSED7 = 3'd7;

	localparam int SET_BOX = 0;
	localparam int SET_RANDOM = 1;
	localparam int SET_EXTREME = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid;
	logic req_stall;
	fcull_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	fcull_pkg::rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	logic [63:0] plane_regs [NUM_PLANES];
	fcull_pkg::req_t pending_queries [$];
	fcull_pkg::rsp_t expected_rsps [$];
	bit calm = 1'b0;
	int errors = 0;
	int rsp_beats = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	frustum_cull_tests i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// exact plane value with 30 fraction bits; dmul scales d
	function automatic logic signed [63:0] plane_eval(int p, logic signed [63:0] x,
			logic signed [63:0] y, logic signed [63:0] z, logic signed [63:0] dmul);
		logic signed [63:0] a, b, c, d;
		a = $signed(plane_regs[p][15:0]);
		b = $signed(plane_regs[p][31:16]);
		c = $signed(plane_regs[p][47:32]);
		d = $signed(plane_regs[p][63:48]);
		return a * x + b * y + c * z + d * dmul * 64'sh4000_0000;
	endfunction

	function automatic logic [31:0] clamp_dist(logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF)
			return 32'h7FFF_FFFF;
		return v[31:0];
	endfunction

	function automatic logic [127:0] ext_sq(logic signed [63:0] lo_v, logic signed [63:0] hi_v);
		logic signed [63:0] e;
		logic [127:0] u;
		e = hi_v - lo_v;
		if (e < 0)
			e = -e;
		u = {64'd0, e};
		return u * u;
	endfunction

	function automatic fcull_pkg::rsp_t cull_predict(fcull_pkg::req_t q);
		fcull_pkg::rsp_t r;
		logic signed [63:0] x0, y0, z0, x1, y1, z1, r14, t14, qv;
		logic [127:0] sum, cand;
		logic [63:0] root;
		bit hit;
		x0 = $signed(q.ax); y0 = $signed(q.ay); z0 = $signed(q.az);
		x1 = $signed(q.bx); y1 = $signed(q.by); z1 = $signed(q.bz);
		r14 = {33'd0, q.radius} << fcull_pkg::COEF_FRAC;
		r = '0;
		case (q.func)
			fcull_pkg::FUNC_POINT: begin
				r.inside_res = 1'b1;
				for (int p = 0; p < NUM_PLANES; p++)
					if (plane_eval(p, x0, y0, z0, 1) <= 0)
						r.inside_res = 1'b0;
			end
			fcull_pkg::FUNC_SPHERE, fcull_pkg::FUNC_SPHERE_DIST: begin
				r.inside_res = 1'b1;
				for (int p = 0; p < NUM_PLANES; p++)
					if (plane_eval(p, x0, y0, z0, 1) <= -r14)
						r.inside_res = 1'b0;
				if (q.func == fcull_pkg::FUNC_SPHERE_DIST && r.inside_res)
					r.near_dist = clamp_dist((plane_eval(REG_NEAR, x0, y0, z0, 1) + r14)
						>>> fcull_pkg::COEF_FRAC);
			end
			fcull_pkg::FUNC_BOX: begin
				r.inside_res = 1'b1;
				for (int p = 0; p < NUM_PLANES; p++) begin
					hit = 1'b0;
					for (int k = 0; k < 8; k++)
						if (plane_eval(p, k[0] ? x1 : x0, k[1] ? y1 : y0, k[2] ? z1 : z0, 1) > 0)
							hit = 1'b1;
					if (!hit)
						r.inside_res = 1'b0;
				end
			end
			fcull_pkg::FUNC_BOX_DIST: begin
				sum = ext_sq(x0, x1) + ext_sq(y0, y1) + ext_sq(z0, z1);
				root = '0;
				for (int b = 35; b >= 0; b--) begin
					cand = {64'd0, root | (64'd1 << b)};
					if (cand * cand <= sum)
						root = cand[63:0];
				end
				t14 = $signed(root << fcull_pkg::COEF_FRAC);
				qv = plane_eval(REG_NEAR, x0 + x1, y0 + y1, z0 + z1, 2);
				if (qv > -t14) begin
					r.inside_res = 1'b1;
					r.near_dist = clamp_dist((qv + t14) >>> (fcull_pkg::COEF_FRAC + 1));
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rand_coord();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return $urandom_range(0, 600 * 65536) - 300 * 65536;
	endfunction

	function automatic fcull_pkg::req_t rand_query();
		fcull_pkg::req_t q;
		q.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(FUNC_UNUSED5, FUNC_UNUSED7))
			: 3'($urandom_range(fcull_pkg::FUNC_POINT, fcull_pkg::FUNC_BOX_DIST));
		q.ax = rand_coord();
		q.ay = rand_coord();
		q.az = rand_coord();
		q.radius = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 60 << 16));
		if ($urandom_range(0, 3) == 0) begin
			q.bx = rand_coord();
			q.by = rand_coord();
			q.bz = rand_coord();
		end else begin
			// mostly well-ordered small boxes
			q.bx = q.ax + $urandom_range(0, 40 << 16);
			q.by = q.ay + $urandom_range(0, 40 << 16);
			q.bz = q.az + $urandom_range(0, 40 << 16);
		end
		return q;
	endfunction

	function automatic logic [63:0] make_plane(int kind, int idx);
		logic [15:0] a, b, c, d;
		a = '0; b = '0; c = '0;
		d = 16'($urandom_range(20, 250));
		case (kind)
			SET_BOX: begin
				case (idx)
					REG_RIGHT: a = -16'sd16384;
					REG_LEFT: a = 16'sd16384;
					REG_BOTTOM: b = 16'sd16384;
					REG_TOP: b = -16'sd16384;
					REG_FAR: c = -16'sd16384;
					default: c = 16'sd16384;
				endcase
			end
			SET_EXTREME: begin
				a = idx[0] ? 16'h8000 : 16'h7FFF;
				b = idx[1] ? 16'h8000 : 16'h7FFF;
				c = idx[2] ? 16'h7FFF : 16'h8000;
				d = (idx > 2) ? 16'h8000 : 16'h7FFF;
			end
			default: return {$urandom, $urandom};
		endcase
		return {d, c, b, a};
	endfunction

	task automatic plane_write(int idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(8 * idx);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		plane_regs[idx] = val;
	endtask

	task automatic load_planes(int kind);
		for (int i = 0; i < NUM_PLANES; i++)
			plane_write(i, make_plane(kind, i));
	endtask

	task automatic drain();
		@(negedge clk);
		while (pending_queries.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	task automatic add_query(logic [2:0] f, logic [31:0] x0, logic [31:0] y0, logic [31:0] z0,
			logic [30:0] rad, logic [31:0] x1, logic [31:0] y1, logic [31:0] z1);
		fcull_pkg::req_t q;
		q.func = f; q.ax = x0; q.ay = y0; q.az = z0;
		q.radius = rad; q.bx = x1; q.by = y1; q.bz = z1;
		pending_queries.push_back(q);
	endtask

	// request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall)
				expected_rsps.push_back(cull_predict(req));
			if (!req_valid || !req_stall) begin
				if (pending_queries.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
					req_valid <= 1'b1;
					req <= pending_queries.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response side
	always @(posedge clk or negedge arst_n) begin
		fcull_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				rsp_beats++;
				if (expected_rsps.size() == 0) begin
					$display("%0t: rsp beat with nothing expected, got %h", $time, rsp);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.inside_res !== want.inside_res) begin
						$display("%0t: inside_res expected %b got %b", $time,
							want.inside_res, rsp.inside_res);
						errors++;
					end
					if (rsp.near_dist !== want.near_dist) begin
						$display("%0t: near_dist expected %h got %h", $time,
							want.near_dist, rsp.near_dist);
						errors++;
					end
				end
				// long hold-off so the pipeline backs up into req
				if (rsp_beats == 500)
					hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= !calm && $urandom_range(0, 99) < 32;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int kinds [6] = '{SET_BOX, SET_RANDOM, SET_BOX, SET_EXTREME, SET_RANDOM, SET_BOX};
		for (int i = 0; i < NUM_PLANES; i++)
			plane_regs[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all-zero planes after reset
		add_query(fcull_pkg::FUNC_POINT, 0, 0, 0, 0, 0, 0, 0);
		add_query(fcull_pkg::FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 0);
		add_query(fcull_pkg::FUNC_SPHERE, 32'h10000, 0, 0, 31'h1, 0, 0, 0);
		add_query(fcull_pkg::FUNC_SPHERE_DIST, 0, 0, 0, 31'h7FFF_FFFF, 0, 0, 0);
		add_query(fcull_pkg::FUNC_BOX, 0, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000);
		add_query(fcull_pkg::FUNC_BOX_DIST, 0, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			calm = (ph == 2);
			load_planes(kinds[ph]);
			if (ph == 0) begin
				add_query(fcull_pkg::FUNC_POINT, 0, 0, 0, 0, 0, 0, 0);
				add_query(fcull_pkg::FUNC_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
					0, 0, 0, 0);
				add_query(fcull_pkg::FUNC_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					0, 0, 0, 0);
				add_query(fcull_pkg::FUNC_SPHERE, 32'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF, 0, 0, 0);
				add_query(fcull_pkg::FUNC_SPHERE, 32'h0100_0000, 0, 0, 31'h0, 0, 0, 0);
				add_query(fcull_pkg::FUNC_SPHERE_DIST, 0, 0, 0, 31'h7FFF_FFFF, 0, 0, 0);
				add_query(fcull_pkg::FUNC_SPHERE_DIST, 0, 0, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
					0, 0, 0);
				add_query(fcull_pkg::FUNC_SPHERE_DIST, 0, 0, 0, 31'h0A_0000, 0, 0, 0);
				add_query(fcull_pkg::FUNC_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
					32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				add_query(fcull_pkg::FUNC_BOX, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 0);
				add_query(fcull_pkg::FUNC_BOX, 32'h0200_0000, 0, 0, 0, 32'h0300_0000,
					32'h10000, 32'h10000);
				add_query(fcull_pkg::FUNC_BOX_DIST, 32'h8000_0000, 32'h8000_0000,
					32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				add_query(fcull_pkg::FUNC_BOX_DIST, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
				add_query(fcull_pkg::FUNC_BOX_DIST, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				add_query(fcull_pkg::FUNC_BOX_DIST, 32'h0500_0000, 0, 0, 0, 32'h0100_0000,
					0, 0);
				add_query(FUNC_UNUSED5, 32'h10000, 0, 0, 31'h1, 0, 0, 0);
				add_query(FUNC_UNUSED6, 0, 0, 0, 0, 0, 0, 0);
				add_query(FUNC_UNUSED7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
					31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				pending_queries.push_back(rand_query());
			drain();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
src/fcull_pkg.sv
src/frustum_cull_tests.sv
tb/tb_frustum_cull_tests.sv
